FILE: hdl/gcd_pkg.sv
// shared constants, cordic arctangent table and helpers for the distance core
package gcd_pkg;

    localparam int unsigned WORD_W = 40;
    localparam logic signed [WORD_W-1:0] GAIN_Q30 = 40'sd652032874;
    localparam logic signed [WORD_W-1:0] QUARTER_TURN = 40'sd1073741824;
    localparam logic signed [WORD_W-1:0] HALF_TURN = 40'sd2147483648;
    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic [24:0] DIST_MAX = 25'd26353663;
    localparam logic [22:0] RADIUS_RESET = 23'd6372795;
    localparam logic [1:0] REG_RADIUS = 2'd0;

    typedef logic signed [WORD_W-1:0] word_t;

    // one cordic lane: x, y, z
    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } cvec_t;

    function automatic logic [31:0] atan_turn(input int unsigned k);
        logic [31:0] r;
        begin
            case (k & 31)
                0: r = 32'h20000000;
                1: r = 32'h12E4051E;
                2: r = 32'h09FB385B;
                3: r = 32'h051111D4;
                4: r = 32'h028B0D43;
                5: r = 32'h0145D7E1;
                6: r = 32'h00A2F61E;
                7: r = 32'h00517C55;
                8: r = 32'h0028BE53;
                9: r = 32'h00145F2F;
                10: r = 32'h000A2F98;
                11: r = 32'h000517CC;
                12: r = 32'h00028BE6;
                13: r = 32'h000145F3;
                14: r = 32'h0000A2FA;
                15: r = 32'h0000517D;
                16: r = 32'h000028BE;
                17: r = 32'h0000145F;
                18: r = 32'h00000A30;
                19: r = 32'h00000518;
                20: r = 32'h0000028C;
                21: r = 32'h00000146;
                22: r = 32'h000000A3;
                23: r = 32'h00000051;
                24: r = 32'h00000029;
                25: r = 32'h00000014;
                26: r = 32'h0000000A;
                27: r = 32'h00000005;
                28: r = 32'h00000003;
                29: r = 32'h00000001;
                30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

    // rotation step: turn positive when z >= 0
    function automatic cvec_t rot_step(input cvec_t v, input int unsigned k);
        cvec_t r;
        word_t a;
        begin
            a = word_t'({8'd0, atan_turn(k)});
            if (v.z >= 0)
            begin
                r.x = v.x - (v.y >>> (k & 31));
                r.y = v.y + (v.x >>> (k & 31));
                r.z = v.z - a;
            end
            else
            begin
                r.x = v.x + (v.y >>> (k & 31));
                r.y = v.y - (v.x >>> (k & 31));
                r.z = v.z + a;
            end
            return r;
        end
    endfunction

    // vectoring step: drive y to zero
    function automatic cvec_t vec_step(input cvec_t v, input int unsigned k);
        cvec_t r;
        word_t a;
        begin
            a = word_t'({8'd0, atan_turn(k)});
            if (v.y >= 0)
            begin
                r.x = v.x + (v.y >>> (k & 31));
                r.y = v.y - (v.x >>> (k & 31));
                r.z = v.z + a;
            end
            else
            begin
                r.x = v.x - (v.y >>> (k & 31));
                r.y = v.y + (v.x >>> (k & 31));
                r.z = v.z - a;
            end
            return r;
        end
    endfunction

    // q30 product, floor; sines, cosines and magnitudes stay within 32 bits signed
    function automatic word_t qmul(input word_t a, input word_t b);
        logic signed [31:0] a_n;
        logic signed [31:0] b_n;
        logic signed [63:0] p;
        begin
            a_n = a[31:0];
            b_n = b[31:0];
            p = a_n * b_n;
            return word_t'(p >>> 30);
        end
    endfunction

endpackage

FILE: hdl/great_circle_distance_core.sv
// great-circle distance core: deep pipeline of cordic and multiply stages
// throughput: one position pair per cycle, busy is held low
// the cordic chains (three rotations, then two vectorings) set the latency
// reset: radius register returns to 6372795 m, all pipeline valid bits clear
// no result is lost: the receiver takes done in the cycle it is shown
module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int CORDIC_STAGES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [27:0] first_latitude,
    input  logic signed [28:0] first_longitude,
    input  logic signed [27:0] second_latitude,
    input  logic signed [28:0] second_longitude,
    output logic        done,
    output logic [24:0] distance_m,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // degree to turn: (m*2^32 + 180*2^F) / (360*2^F) reduces to (m*2^SH + 22) / 45
    localparam int SH = 29 - ANGLE_FRAC_BITS;
    // reciprocal of 45 in 2^-36, estimate is exact or one low
    localparam logic [30:0] RECIP45 = 31'((64'd1 << 36) / 64'd45);
    localparam int NS = CORDIC_STAGES;

    logic [22:0] radius_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign busy = 1'b0;
    assign wr_en = psel && penable && pwrite;
    assign prdata = (paddr[1:0] == gcd_pkg::REG_RADIUS) ? {9'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= gcd_pkg::RADIUS_RESET;
        else if (wr_en && paddr == gcd_pkg::REG_RADIUS)
            radius_reg <= pwdata[22:0];
    end

    // ---- stage 0: capture inputs, longitude difference
    logic v0_reg;
    logic signed [29:0] a0_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        a0_reg[0] <= 30'(first_latitude);
        a0_reg[1] <= 30'(second_latitude);
        a0_reg[2] <= 30'(first_longitude) - 30'(second_longitude);
    end

    // ---- stage 1: sign and magnitude
    logic v1_reg;
    logic [29:0] mag1_reg [3];
    logic neg1_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_reg[i] <= a0_reg[i][29];
            mag1_reg[i] <= a0_reg[i][29] ? 30'(-a0_reg[i]) : 30'(a0_reg[i]);
        end
    end

    // stage 2: magnitude / 45 estimate
    logic v2_reg;
    logic [24:0] h2_reg [3];
    logic [29:0] mag2_reg [3];
    logic neg2_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [60:0] p;
            p = 61'(mag1_reg[i]) * 61'(RECIP45);
            h2_reg[i] <= p[60:36];
            mag2_reg[i] <= mag1_reg[i];
            neg2_reg[i] <= neg1_reg[i];
        end
    end

    // stage 3: correct quotient, keep remainder
    logic v3_reg;
    logic [24:0] h3_reg [3];
    logic [5:0] r3_reg [3];
    logic neg3_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [29:0] rem;
            rem = mag2_reg[i] - 30'(h2_reg[i]) * 30'd45;
            if (rem >= 30'd45)
            begin
                h3_reg[i] <= h2_reg[i] + 25'd1;
                r3_reg[i] <= 6'(rem - 30'd45);
            end
            else
            begin
                h3_reg[i] <= h2_reg[i];
                r3_reg[i] <= rem[5:0];
            end
            neg3_reg[i] <= neg2_reg[i];
        end
    end

    // stage 4: low quotient bits from remainder, estimate
    logic vf_reg;
    logic [24:0] hf_reg [3];
    logic [22:0] nf_reg [3];
    logic [17:0] ef_reg [3];
    logic negf_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else
            vf_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [22:0] x;
            logic [53:0] p;
            x = (23'(r3_reg[i]) << SH) + 23'd22;
            p = 54'(x) * 54'(RECIP45);
            ef_reg[i] <= p[53:36];
            nf_reg[i] <= x;
            hf_reg[i] <= h3_reg[i];
            negf_reg[i] <= neg3_reg[i];
        end
    end

    // stage 5: correct low bits, assemble turn value modulo one turn
    logic vq_reg;
    logic [31:0] q_reg [3];
    logic negq_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= 1'b0;
        else
            vq_reg <= vf_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [22:0] rem;
            logic [17:0] frac;
            rem = nf_reg[i] - 23'(ef_reg[i]) * 23'd45;
            frac = (rem >= 23'd45) ? ef_reg[i] + 18'd1 : ef_reg[i];
            q_reg[i] <= (32'(hf_reg[i]) << SH) + 32'(frac);
            negq_reg[i] <= negf_reg[i];
        end
    end

    // stage 6: apply sign, fold, seed rotation
    logic vs_reg;
    gcd_pkg::cvec_t seed_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg <= 1'b0;
        else
            vs_reg <= vq_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [31:0] b;
            gcd_pkg::cvec_t s;
            b = negq_reg[i] ? -q_reg[i] : q_reg[i];
            s.x = gcd_pkg::GAIN_Q30;
            s.y = '0;
            s.z = gcd_pkg::word_t'($signed(b));
            if (s.z > gcd_pkg::QUARTER_TURN)
            begin
                s.z = s.z - gcd_pkg::HALF_TURN;
                s.x = -gcd_pkg::GAIN_Q30;
            end
            else if (s.z < -gcd_pkg::QUARTER_TURN)
            begin
                s.z = s.z + gcd_pkg::HALF_TURN;
                s.x = -gcd_pkg::GAIN_Q30;
            end
            seed_reg[i] <= s;
        end
    end

    // rotation stages
    gcd_pkg::cvec_t rp [NS+1][3];
    logic rv [NS+1];
    assign rp[0] = seed_reg;
    assign rv[0] = vs_reg;
    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_rot
            gcd_pkg::cvec_t st_reg [3];
            logic sv_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg <= 1'b0;
                else
                    sv_reg <= rv[g];
            end
            always_ff @(posedge clk)
            begin
                for (int i = 0; i < 3; i++)
                    st_reg[i] <= gcd_pkg::rot_step(rp[g][i], g);
            end
            assign rp[g+1] = st_reg;
            assign rv[g+1] = sv_reg;
        end
    endgenerate

    // products: c1=x0 s1=y0 c2=x1 s2=y1 cd=x2 sd=y2
    logic v4_reg;
    gcd_pkg::word_t c1s2_4_reg, s1c2_4_reg, c2sd_4_reg, s1s2_4_reg, c1c2_4_reg, cd_4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= rv[NS];
    end
    always_ff @(posedge clk)
    begin
        c1s2_4_reg <= gcd_pkg::qmul(rp[NS][0].x, rp[NS][1].y);
        s1c2_4_reg <= gcd_pkg::qmul(rp[NS][0].y, rp[NS][1].x);
        c2sd_4_reg <= gcd_pkg::qmul(rp[NS][1].x, rp[NS][2].y);
        s1s2_4_reg <= gcd_pkg::qmul(rp[NS][0].y, rp[NS][1].y);
        c1c2_4_reg <= gcd_pkg::qmul(rp[NS][0].x, rp[NS][1].x);
        cd_4_reg <= rp[NS][2].x;
    end

    logic v5_reg;
    gcd_pkg::word_t c1s2_5_reg, c2sd_5_reg, s1s2_5_reg, p1_5_reg, p2_5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        c1s2_5_reg <= c1s2_4_reg;
        c2sd_5_reg <= c2sd_4_reg;
        s1s2_5_reg <= s1s2_4_reg;
        p1_5_reg <= gcd_pkg::qmul(s1c2_4_reg, cd_4_reg);
        p2_5_reg <= gcd_pkg::qmul(c1c2_4_reg, cd_4_reg);
    end

    // a, b, zt; seed root vectoring
    logic v6_reg;
    gcd_pkg::cvec_t m6_reg;
    gcd_pkg::word_t zt6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        gcd_pkg::word_t a;
        a = c1s2_5_reg - p1_5_reg;
        m6_reg.x <= (a < 0) ? -a : a;
        m6_reg.y <= c2sd_5_reg;
        m6_reg.z <= '0;
        zt6_reg <= s1s2_5_reg + p2_5_reg;
    end

    gcd_pkg::cvec_t mp [NS+1];
    gcd_pkg::word_t mz [NS+1];
    logic mv [NS+1];
    assign mp[0] = m6_reg;
    assign mz[0] = zt6_reg;
    assign mv[0] = v6_reg;
    generate
        for (g = 0; g < NS; g++)
        begin : g_root
            gcd_pkg::cvec_t st_reg;
            gcd_pkg::word_t zt_reg;
            logic sv_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg <= 1'b0;
                else
                    sv_reg <= mv[g];
            end
            always_ff @(posedge clk)
            begin
                st_reg <= gcd_pkg::vec_step(mp[g], g);
                zt_reg <= mz[g];
            end
            assign mp[g+1] = st_reg;
            assign mz[g+1] = zt_reg;
            assign mv[g+1] = sv_reg;
        end
    endgenerate

    // magnitude times gain, then seed atan2
    logic v7_reg;
    gcd_pkg::word_t m7_reg, zt7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= mv[NS];
    end
    always_ff @(posedge clk)
    begin
        m7_reg <= gcd_pkg::qmul(mp[NS].x, gcd_pkg::GAIN_Q30);
        zt7_reg <= mz[NS];
    end

    logic v8_reg;
    gcd_pkg::cvec_t t8_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        if (zt7_reg < 0)
        begin
            t8_reg.x <= m7_reg;
            t8_reg.y <= -zt7_reg;
            t8_reg.z <= gcd_pkg::QUARTER_TURN;
        end
        else
        begin
            t8_reg.x <= zt7_reg;
            t8_reg.y <= m7_reg;
            t8_reg.z <= '0;
        end
    end

    gcd_pkg::cvec_t ap [NS+1];
    logic av [NS+1];
    assign ap[0] = t8_reg;
    assign av[0] = v8_reg;
    generate
        for (g = 0; g < NS; g++)
        begin : g_atan
            gcd_pkg::cvec_t st_reg;
            logic sv_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg <= 1'b0;
                else
                    sv_reg <= av[g];
            end
            always_ff @(posedge clk)
                st_reg <= gcd_pkg::vec_step(ap[g], g);
            assign ap[g+1] = st_reg;
            assign av[g+1] = sv_reg;
        end
    endgenerate

    // angle times radius
    logic v9_reg;
    logic [54:0] t9_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= av[NS];
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] ang;
        ang = (ap[NS].z < 0) ? 32'd0 : 32'(ap[NS].z);
        t9_reg <= 55'(ang) * 55'(radius_reg);
    end

    // times 2*pi in two partial products
    logic v10_reg;
    logic [53:0] hi10_reg;
    logic [62:0] lo10_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10_reg <= 1'b0;
        else
            v10_reg <= v9_reg;
    end
    always_ff @(posedge clk)
    begin
        hi10_reg <= 54'(t9_reg[54:32]) * 54'(gcd_pkg::TWO_PI_Q28);
        lo10_reg <= 63'(t9_reg[31:0]) * 63'(gcd_pkg::TWO_PI_Q28) + (63'd1 << 59);
    end

    logic v11_reg;
    logic [24:0] d11_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v11_reg <= 1'b0;
        else
            v11_reg <= v10_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [54:0] s;
        logic [26:0] d;
        s = 55'(hi10_reg) + 55'(lo10_reg[62:32]);
        d = s[54:28];
        d11_reg <= (d > 27'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : d[24:0];
    end

    assign done = v11_reg;
    assign distance_m = d11_reg;

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> distance_m <= gcd_pkg::DIST_MAX)
        else $error("distance above saturation");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v10_reg |=> done)
        else $error("result lost in last stage");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> v0_reg)
        else $error("start not captured");

endmodule

FILE: sim/great_circle_distance_core_test.sv
// self-checking testbench for the great-circle distance core
module great_circle_distance_core_test;

    localparam int LATENCY = 24 * 3 + 14;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 330;

    // distances still owed by the core, oldest first
    class distance_board;
        logic [24:0] owed[$];
        int mismatches = 0;

        function void note(input logic [24:0] d);
            owed.push_back(d);
        endfunction

        function void check(input logic [24:0] got);
            logic [24:0] want;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance transfer: %0d", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance_m mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [27:0] first_latitude = '0;
    logic signed [28:0] first_longitude = '0;
    logic signed [27:0] second_latitude = '0;
    logic signed [28:0] second_longitude = '0;
    logic        done;
    logic [24:0] distance_m;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    distance_board board = new();
    logic [22:0] radius_copy = gcd_pkg::RADIUS_RESET;
    int stall_cycles = 0;
    bit quiet = 1'b0;

    great_circle_distance_core dut (.*);

    always #5 clk = ~clk;

    localparam longint ARC[32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h00000000};
    localparam longint K_GAIN = 652032874;
    localparam longint K_QUARTER = 64'd1073741824;
    localparam longint K_HALF = 64'd2147483648;

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [31:0] deg_to_turns(input longint x);
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] b;
        den = 64'd360 << 20;
        mag = (x < 0) ? -x : x;
        b = ((mag << 32) + den / 2) / den;
        if (x < 0)
            b = -b;
        return b[31:0];
    endfunction

    task automatic rotate(input logic [31:0] a, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        z = (a >= 32'h80000000) ? longint'({32'd0, a}) - 2 * K_HALF : longint'({32'd0, a});
        x = K_GAIN;
        y = 0;
        // fold beyond a quarter turn, start vector negated
        if (z > K_QUARTER)
        begin
            z -= K_HALF;
            x = -K_GAIN;
        end
        else if (z < -K_QUARTER)
        begin
            z += K_HALF;
            x = -K_GAIN;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ARC[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ARC[i];
            end
            x = nx;
        end
        c = x;
        s = y;
    endtask

    task automatic vector(input longint x0, input longint y0, input longint z0,
                          output longint xo, output longint zo);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = x0;
        y = y0;
        z = z0;
        for (int i = 0; i < 24; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ARC[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ARC[i];
            end
            x = nx;
        end
        xo = x;
        zo = z;
    endtask

    task automatic predict_distance(input logic signed [27:0] la1, input logic signed [28:0] lo1,
                                    input logic signed [27:0] la2, input logic signed [28:0] lo2,
                                    input logic [22:0] radius, output logic [24:0] d);
        longint c1, s1, c2, s2, cd, sd, a, b, zt, m, xf, ang;
        logic [63:0] t, th, tl, big, dist_v;
        rotate(deg_to_turns(la1), c1, s1);
        rotate(deg_to_turns(la2), c2, s2);
        rotate(deg_to_turns(longint'(lo1) - longint'(lo2)), cd, sd);
        a = fx_mul(c1, s2) - fx_mul(fx_mul(s1, c2), cd);
        b = fx_mul(c2, sd);
        zt = fx_mul(s1, s2) + fx_mul(fx_mul(c1, c2), cd);
        vector((a < 0) ? -a : a, b, 0, xf, ang);
        m = fx_mul(xf, K_GAIN);
        if (zt < 0)
            vector(m, -zt, K_QUARTER, xf, ang);
        else
            vector(zt, m, 0, xf, ang);
        // small negative residue from the vectoring counts as zero
        if (ang < 0)
            ang = 0;
        t = ang * radius;
        th = t >> 32;
        tl = t & 64'hFFFFFFFF;
        big = tl * 64'd1686629713 + (64'd1 << 59);
        dist_v = (th * 64'd1686629713 + (big >> 32)) >> 28;
        if (dist_v > gcd_pkg::DIST_MAX)
            dist_v = gcd_pkg::DIST_MAX;
        d = dist_v[24:0];
    endtask

    // input and result transfers, plus stall watchdog
    always @(posedge clk)
    begin
        logic [24:0] d;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_distance(first_latitude, first_longitude, second_latitude,
                                 second_longitude, radius_copy, d);
                board.note(d);
            end
            if (done)
                board.check(distance_m);
            if ((start && !busy) || done || psel)
                stall_cycles = 0;
            else if (board.owed.size() != 0 || start)
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** great_circle_distance_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.owed.size() != 0);
    endtask

    task automatic write_radius(input logic [31:0] v);
        wait_drained();
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= gcd_pkg::REG_RADIUS;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        radius_copy = v[22:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(input logic signed [27:0] la1, input logic signed [28:0] lo1,
                        input logic signed [27:0] la2, input logic signed [28:0] lo2);
        int gap;
        start <= 1'b1;
        first_latitude <= la1;
        first_longitude <= lo1;
        second_latitude <= la2;
        second_longitude <= lo2;
        do
            @(posedge clk);
        while (busy);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [27:0] rand_lat();
        case ($urandom_range(0, 3))
            0: return 28'($urandom);
            1: return 28'($signed($urandom_range(0, 188743680)) - 94371840);
            2: return $urandom_range(0, 1) ? 28'sd94371840 : -28'sd94371840;
            default: return 28'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic signed [28:0] rand_lon();
        case ($urandom_range(0, 3))
            0: return 29'($urandom);
            1: return 29'($signed($urandom_range(0, 377487360)) - 188743680);
            2: return $urandom_range(0, 1) ? 29'sd188743680 : -29'sd188743680;
            default: return 29'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic signed [27:0] la;
        logic signed [28:0] lo;
        for (int i = 0; i < n; i++)
        begin
            la = rand_lat();
            lo = rand_lon();
            // nearby and antipodal pairs are where the atan2 branches matter
            case ($urandom_range(0, 3))
                0: send(la, lo, la + 28'($signed($urandom_range(0, 64)) - 32),
                        lo + 29'($signed($urandom_range(0, 64)) - 32));
                1: send(la, lo, -la, lo + 29'sd188743680);
                default: send(la, lo, rand_lat(), rand_lon());
            endcase
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, poles, antipodes, identical points, out-of-range
        send(0, 0, 0, 0);
        send(28'sd94371840, 0, -28'sd94371840, 0);
        send(0, 0, 0, 29'sd188743680);
        send(0, -29'sd188743680, 0, 29'sd188743680);
        send(28'sd2048, 29'sd1000, 28'sd2048, 29'sd1000);
        send(28'sh7FFFFFF, 29'shFFFFFFF, 28'sh8000000, 29'sh10000000);
        send(28'sh8000000, 29'sh10000000, 28'sh7FFFFFF, 29'shFFFFFFF);
        send(28'sh8000000, 29'sh10000000, 28'sh8000000, 29'shFFFFFFF);
        send(28'sd94371841, 29'sd5, -28'sd94371841, -29'sd5);
        send(28'sd50000000, 29'sd100000000, -28'sd50000000, -29'sd88743680);
        send(-28'sd1, -29'sd1, 28'sd1, 29'sd1);
        send(28'sd10485760, 29'sd20971520, 28'sd10485761, 29'sd20971520);
        send(0, 0, 0, 29'sd94371840);
        send(0, 0, 28'sd47185920, 29'sd188743679);
        write_radius(32'd8388607);
        send(0, 0, 0, 29'sd188743680);
        send(28'sd94371840, 0, -28'sd94371840, 29'sd1234);
        write_radius(32'hFF800000);
        send(0, 0, 0, 29'sd188743680);
        send(28'sd1000000, 29'sd3000, -28'sd1000000, 29'sd70000000);
        write_radius(32'd1);
        send(0, 0, 0, 29'sd188743680);

        random_phase(PHASE_ITEMS);
        write_radius(32'd8388607);
        random_phase(PHASE_ITEMS / 2);
        wait_drained();
        random_phase(PHASE_ITEMS / 2);
        write_radius({$urandom} | 32'h1);
        random_phase(PHASE_ITEMS);
        write_radius(32'd0);
        random_phase(PHASE_ITEMS / 3);
        write_radius(32'h007FFFFF & ~{$urandom});
        random_phase(PHASE_ITEMS);
        write_radius(32'd6372795);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("** great_circle_distance_core: PASSED **");
        else
            $display("** great_circle_distance_core: FAILED **");
        $finish;
    end

endmodule
